// File: rtl/vnorm_pkg.sv
// Shared constants for the vector normalization core.
package vnorm_pkg;

    // Fraction bits of the unit vector components (1.0 is 2**22).
    localparam int UNIT_FRAC = 22;
    // Width of a unit component on the output word.
    localparam int UNIT_W = 24;
    // Width of the length on the output word.
    localparam int LEN_W = 24;
    // Quotient bits per component: the quotient never exceeds 2**22.
    localparam int QUOT_W = UNIT_FRAC + 1;

endpackage

// File: rtl/vnorm_sqrt_cell.sv
// One cell of the square root chain: settles one bit of the root.
module vnorm_sqrt_cell
    import vnorm_pkg::*;
#(
    parameter int W   = 24,
    parameter int BIT = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid_in,
    input  logic [2*W-1:0]   rem_in,
    input  logic [W-1:0]     root_in,
    input  logic [3*W-1:0]   mag_in,
    input  logic [2:0]       neg_in,
    input  logic             zero_in,
    output logic             valid_out,
    output logic [2*W-1:0]   rem_out,
    output logic [W-1:0]     root_out,
    output logic [3*W-1:0]   mag_out,
    output logic [2:0]       neg_out,
    output logic             zero_out
);

    localparam int SW = 2 * W;

    logic [SW-1:0] trial;
    logic          take;
    logic          valid_reg;
    logic [SW-1:0] rem_reg;
    logic [W-1:0]  root_reg;
    logic [3*W-1:0] mag_reg;
    logic [2:0]    neg_reg;
    logic          zero_reg;

    // Trial subtrahend (2*root + 2**BIT) * 2**BIT; root bits below BIT+1 are still zero.
    always_comb
    begin
        trial = ((SW'(root_in) << 1) | (SW'(1) << BIT)) << BIT;
        take  = (rem_in >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= take ? (rem_in - trial) : rem_in;
            root_reg <= take ? (root_in | (W'(1) << BIT)) : root_in;
            mag_reg  <= mag_in;
            neg_reg  <= neg_in;
            zero_reg <= zero_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign mag_out   = mag_reg;
    assign neg_out   = neg_reg;
    assign zero_out  = zero_reg;

endmodule

// File: rtl/vnorm_div_cell.sv
// One cell of the division chain: settles one quotient bit for all three components.
module vnorm_div_cell
    import vnorm_pkg::*;
#(
    parameter int W   = 24,
    parameter int BIT = 0
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     valid_in,
    input  logic [W-1:0]             len_in,
    input  logic [3*(W+QUOT_W)-1:0]  rem_in,
    input  logic [3*QUOT_W-1:0]      quot_in,
    input  logic [2:0]               neg_in,
    input  logic                     zero_in,
    output logic                     valid_out,
    output logic [W-1:0]             len_out,
    output logic [3*(W+QUOT_W)-1:0]  rem_out,
    output logic [3*QUOT_W-1:0]      quot_out,
    output logic [2:0]               neg_out,
    output logic                     zero_out
);

    localparam int DW = W + QUOT_W;

    logic [DW-1:0]          dvs;
    logic [3*DW-1:0]        rem_next;
    logic [3*QUOT_W-1:0]    quot_next;
    logic                   valid_reg;
    logic [W-1:0]           len_reg;
    logic [3*DW-1:0]        rem_reg;
    logic [3*QUOT_W-1:0]    quot_reg;
    logic [2:0]             neg_reg;
    logic                   zero_reg;

    // Restoring step on each lane against the shifted length.
    always_comb
    begin
        dvs = DW'(len_in) << BIT;
        for (int i = 0; i < 3; i++)
        begin
            if (rem_in[i*DW +: DW] >= dvs)
            begin
                rem_next[i*DW +: DW]         = rem_in[i*DW +: DW] - dvs;
                quot_next[i*QUOT_W +: QUOT_W] =
                    quot_in[i*QUOT_W +: QUOT_W] | (QUOT_W'(1) << BIT);
            end
            else
            begin
                rem_next[i*DW +: DW]         = rem_in[i*DW +: DW];
                quot_next[i*QUOT_W +: QUOT_W] = quot_in[i*QUOT_W +: QUOT_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg  <= len_in;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            neg_reg  <= neg_in;
            zero_reg <= zero_in;
        end
    end

    assign valid_out = valid_reg;
    assign len_out   = len_reg;
    assign rem_out   = rem_reg;
    assign quot_out  = quot_reg;
    assign neg_out   = neg_reg;
    assign zero_out  = zero_reg;

endmodule

// File: rtl/vector3_normalize_core.sv
// Top level of the vector normalization core: squares, sum, root chain, divide chain.
//
//  Channel   | Direction | Contents
//  s_axis    | in        | tdata: x_in, y_in, z_in (Q8.16, COMPONENT_WIDTH bits each)
//  m_axis    | out       | tdata: x_unit, y_unit, z_unit, length_out; tuser: zero_length
//
// One word enters per cycle unless the output stalls; a word passes through input, square,
// sum, one cell per root bit, one cell per quotient bit and the output register.
// The whole chain advances together whenever the output register is empty or taken,
// so a stall at the output holds every stage in place.
// Reset clears the valid bits of all stages; payload registers are not reset.
module vector3_normalize_core
    import vnorm_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 24
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // Bits from low: x_in, y_in, z_in, zero fill to whole bytes.
    input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // Bits from low: x_unit, y_unit, z_unit, length_out.
    output logic [3*UNIT_W+LEN_W-1:0] m_axis_tdata,
    // Bits from low: zero_length.
    output logic m_axis_tuser
);

    localparam int W  = COMPONENT_WIDTH;
    localparam int SW = 2 * W;
    localparam int DW = W + QUOT_W;

    logic en;

    // Stage registers ahead of the root chain.
    logic            in_valid_reg;
    logic [3*W-1:0]  in_mag_reg;
    logic [2:0]      in_neg_reg;
    logic            in_zero_reg;
    logic            sq_valid_reg;
    logic [3*SW-1:0] sq_reg;
    logic [3*W-1:0]  sq_mag_reg;
    logic [2:0]      sq_neg_reg;
    logic            sq_zero_reg;
    logic            sum_valid_reg;
    logic [SW-1:0]   sum_reg;
    logic [3*W-1:0]  sum_mag_reg;
    logic [2:0]      sum_neg_reg;
    logic            sum_zero_reg;

    logic [3*W-1:0]  mag_next;
    logic [2:0]      neg_next;

    // Root chain taps.
    logic            rt_valid [0:W];
    logic [SW-1:0]   rt_rem   [0:W];
    logic [W-1:0]    rt_root  [0:W];
    logic [3*W-1:0]  rt_mag   [0:W];
    logic [2:0]      rt_neg   [0:W];
    logic            rt_zero  [0:W];

    // Divide chain taps.
    logic                 dv_valid [0:QUOT_W];
    logic [W-1:0]         dv_len   [0:QUOT_W];
    logic [3*DW-1:0]      dv_rem   [0:QUOT_W];
    logic [3*QUOT_W-1:0]  dv_quot  [0:QUOT_W];
    logic [2:0]           dv_neg   [0:QUOT_W];
    logic                 dv_zero  [0:QUOT_W];

    logic                        out_valid_reg;
    logic [3*UNIT_W+LEN_W-1:0]   out_data_reg;
    logic                        out_zero_reg;
    logic [3*UNIT_W+LEN_W-1:0]   out_data_next;
    logic [UNIT_W-1:0]           q_ext;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Split each component into sign and magnitude.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i]         = s_axis_tdata[i*W + W - 1];
            mag_next[i*W +: W]  = neg_next[i] ? (W'(0) - s_axis_tdata[i*W +: W])
                                              : s_axis_tdata[i*W +: W];
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg  <= s_axis_tvalid;
            sq_valid_reg  <= in_valid_reg;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    // Input, square and sum stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_mag_reg  <= mag_next;
            in_neg_reg  <= neg_next;
            in_zero_reg <= (s_axis_tdata[3*W-1:0] == '0);
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i*SW +: SW] <= SW'(in_mag_reg[i*W +: W]) * SW'(in_mag_reg[i*W +: W]);
            end
            sq_mag_reg   <= in_mag_reg;
            sq_neg_reg   <= in_neg_reg;
            sq_zero_reg  <= in_zero_reg;
            sum_reg      <= sq_reg[0 +: SW] + sq_reg[SW +: SW] + sq_reg[2*SW +: SW];
            sum_mag_reg  <= sq_mag_reg;
            sum_neg_reg  <= sq_neg_reg;
            sum_zero_reg <= sq_zero_reg;
        end
    end

    assign rt_valid[0] = sum_valid_reg;
    assign rt_rem[0]   = sum_reg;
    assign rt_root[0]  = '0;
    assign rt_mag[0]   = sum_mag_reg;
    assign rt_neg[0]   = sum_neg_reg;
    assign rt_zero[0]  = sum_zero_reg;

    // Root chain, most significant bit first.
    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        vnorm_sqrt_cell #(
            .W   (W),
            .BIT (W - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (rt_valid[k]),
            .rem_in    (rt_rem[k]),
            .root_in   (rt_root[k]),
            .mag_in    (rt_mag[k]),
            .neg_in    (rt_neg[k]),
            .zero_in   (rt_zero[k]),
            .valid_out (rt_valid[k+1]),
            .rem_out   (rt_rem[k+1]),
            .root_out  (rt_root[k+1]),
            .mag_out   (rt_mag[k+1]),
            .neg_out   (rt_neg[k+1]),
            .zero_out  (rt_zero[k+1])
        );
    end

    // Dividends are the magnitudes scaled up by the unit fraction bits.
    assign dv_valid[0] = rt_valid[W];
    assign dv_len[0]   = rt_root[W];
    assign dv_quot[0]  = '0;
    assign dv_neg[0]   = rt_neg[W];
    assign dv_zero[0]  = rt_zero[W];
    for (genvar i = 0; i < 3; i++)
    begin : g_dvd
        assign dv_rem[0][i*DW +: DW] = DW'(rt_mag[W][i*W +: W]) << UNIT_FRAC;
    end

    // Divide chain, most significant quotient bit first.
    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_div
        vnorm_div_cell #(
            .W   (W),
            .BIT (QUOT_W - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_valid[k]),
            .len_in    (dv_len[k]),
            .rem_in    (dv_rem[k]),
            .quot_in   (dv_quot[k]),
            .neg_in    (dv_neg[k]),
            .zero_in   (dv_zero[k]),
            .valid_out (dv_valid[k+1]),
            .len_out   (dv_len[k+1]),
            .rem_out   (dv_rem[k+1]),
            .quot_out  (dv_quot[k+1]),
            .neg_out   (dv_neg[k+1]),
            .zero_out  (dv_zero[k+1])
        );
    end

    // Restore signs and force a zero vector to zero components.
    always_comb
    begin
        q_ext = '0;
        for (int i = 0; i < 3; i++)
        begin
            q_ext = UNIT_W'(dv_quot[QUOT_W][i*QUOT_W +: QUOT_W]);
            if (dv_zero[QUOT_W])
            begin
                out_data_next[i*UNIT_W +: UNIT_W] = '0;
            end
            else if (dv_neg[QUOT_W][i])
            begin
                out_data_next[i*UNIT_W +: UNIT_W] = UNIT_W'(0) - q_ext;
            end
            else
            begin
                out_data_next[i*UNIT_W +: UNIT_W] = q_ext;
            end
        end
        out_data_next[3*UNIT_W +: LEN_W] = LEN_W'(dv_len[QUOT_W]);
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid[QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_zero_reg <= dv_zero[QUOT_W];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_zero_reg;

endmodule

// File: tb/tb_vector3_normalize_core.sv
// Testbench for the vector normalization core: directed table, random vectors, stream checks.
`timescale 1ns / 100ps

module tb_vector3_normalize_core;
    import vnorm_pkg::*;

    localparam int CW      = 24;
    localparam int IN_W    = ((3*CW+7)/8)*8;
    localparam int LATENCY = CW + 27;
    localparam int N_RAND  = 950;

    typedef struct packed {
        logic [UNIT_W-1:0] xu;
        logic [UNIT_W-1:0] yu;
        logic [UNIT_W-1:0] zu;
        logic [LEN_W-1:0]  len;
        logic              zl;
    } unit_vec_t;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        bit            fixed;
        unit_vec_t     res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // Bits from low: x_in, y_in, z_in.
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // Bits from low: x_unit, y_unit, z_unit, length_out.
    logic [3*UNIT_W+LEN_W-1:0] m_axis_tdata;
    // Bits from low: zero_length.
    logic m_axis_tuser;

    unit_vec_t expected_units[$];
    int        n_errors;
    int        send_idle_pct;
    int        recv_stall_pct;

    vector3_normalize_core #(.COMPONENT_WIDTH(CW)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Digit-by-digit floor square root of the exact sum of squares.
    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Normalize one vector: length in Q8.16, components in Q2.22.
    function automatic unit_vec_t normalize_vec(logic [CW-1:0] x, logic [CW-1:0] y,
                                                logic [CW-1:0] z);
        logic [CW-1:0] comp[3];
        logic [63:0]   mag[3];
        logic [63:0]   q[3];
        logic [63:0]   sumsq;
        logic [63:0]   len;
        unit_vec_t     r;
        comp[0] = x;
        comp[1] = y;
        comp[2] = z;
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            // Magnitude is formed at component width, then zero extended.
            mag[i] = 64'(comp[i][CW-1] ? CW'((~comp[i]) + 1'b1) : comp[i]);
            sumsq  = sumsq + mag[i] * mag[i];
        end
        len = floor_sqrt(sumsq);
        for (int i = 0; i < 3; i++)
        begin
            q[i] = (len != 0) ? (mag[i] << UNIT_FRAC) / len : 64'd0;
            if (comp[i][CW-1])
                q[i] = ~q[i] + 1;
        end
        r.xu  = q[0][UNIT_W-1:0];
        r.yu  = q[1][UNIT_W-1:0];
        r.zu  = q[2][UNIT_W-1:0];
        r.len = len[LEN_W-1:0];
        r.zl  = (sumsq == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Send one word, waiting for the handshake; random idle cycles come first.
    task automatic send_vec(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                            unit_vec_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({z, y, x});
        expected_units.push_back(want);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_comp();
        case ($urandom_range(5))
            0: return CW'($urandom_range(3));
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return {1'b0, {(CW-1){1'b1}}};
            3: return CW'(-$signed(CW'($urandom_range(70000))));
            default: return CW'($urandom);
        endcase
    endfunction

    // Receiver: random stalls and comparison against the oldest expectation.
    always @(posedge clk)
    begin
        unit_vec_t got;
        unit_vec_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[UNIT_W-1:0], m_axis_tdata[2*UNIT_W-1:UNIT_W],
                       m_axis_tdata[3*UNIT_W-1:2*UNIT_W],
                       m_axis_tdata[3*UNIT_W+LEN_W-1:3*UNIT_W], m_axis_tuser};
                if (expected_units.size() == 0)
                begin
                    $display("%0t: unexpected output word", $realtime);
                    n_errors++;
                end
                else
                begin
                    want = expected_units.pop_front();
                    if (got.xu !== want.xu)
                        report_mismatch("x_unit", 32'(got.xu), 32'(want.xu));
                    if (got.yu !== want.yu)
                        report_mismatch("y_unit", 32'(got.yu), 32'(want.yu));
                    if (got.zu !== want.zu)
                        report_mismatch("z_unit", 32'(got.zu), 32'(want.zu));
                    if (got.len !== want.len)
                        report_mismatch("length_out", 32'(got.len), 32'(want.len));
                    if (got.zl !== want.zl)
                        report_mismatch("zero_length", 32'(got.zl), 32'(want.zl));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Main sequence: reset, directed table, then random vectors in phases of source idling and receiver stalls.
    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        logic [CW-1:0] mx;
        logic [CW-1:0] mn;
        logic [CW-1:0] one;
        int cycles;
        mx  = {1'b0, {(CW-1){1'b1}}};
        mn  = {1'b1, {(CW-1){1'b0}}};
        one = CW'(65536);
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        n_errors       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fixed rows: zero vector, unit axes, most negative component alone, smallest component alone.
        rows.push_back('{'0, '0, '0, 1, '{'0, '0, '0, '0, 1'b1}});
        rows.push_back('{one, '0, '0, 1, '{24'd4194304, '0, '0, 24'd65536, 1'b0}});
        rows.push_back('{'0, -one, '0, 1, '{'0, -24'sd4194304, '0, 24'd65536, 1'b0}});
        rows.push_back('{mn, '0, '0, 1, '{-24'sd4194304, '0, '0, 24'd8388608, 1'b0}});
        rows.push_back('{'0, '0, mn, 1, '{'0, '0, -24'sd4194304, 24'd8388608, 1'b0}});
        rows.push_back('{'0, '0, CW'(1), 1, '{'0, '0, 24'd4194304, 24'd1, 1'b0}});
        // Predicted rows: extremes and mixed signs.
        rows.push_back('{mn, mn, mn, 0, '0});
        rows.push_back('{mx, mx, mx, 0, '0});
        rows.push_back('{mx, mn, mx, 0, '0});
        rows.push_back('{CW'(-1), CW'(-1), CW'(-1), 0, '0});
        rows.push_back('{CW'(1), CW'(1), '0, 0, '0});
        rows.push_back('{CW'(3), CW'(-4), '0, 0, '0});
        rows.push_back('{mx, CW'(1), CW'(-1), 0, '0});
        rows.push_back('{CW'(24'h555555), CW'(24'haaaaaa), CW'(24'h0f0f0f), 0, '0});
        rows.push_back('{one, one, one, 0, '0});
        foreach (rows[i])
        begin
            row = rows[i];
            send_vec(row.x, row.y, row.z,
                     row.fixed ? row.res : normalize_vec(row.x, row.y, row.z));
        end

        for (int k = 0; k < N_RAND; k++)
        begin
            logic [CW-1:0] rx;
            logic [CW-1:0] ry;
            logic [CW-1:0] rz;
            case (k * 5 / N_RAND)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                3: begin send_idle_pct = 19; recv_stall_pct = 19; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // Hold off once until the pipeline drains completely.
            if (k == N_RAND / 2)
            begin
                s_axis_tvalid <= 1'b0;
                while (expected_units.size() != 0)
                    @(posedge clk);
            end
            rx = rand_comp();
            ry = rand_comp();
            rz = rand_comp();
            send_vec(rx, ry, rz, normalize_vec(rx, ry, rz));
        end
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;

        cycles = 0;
        while (expected_units.size() != 0 && cycles < 100000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (n_errors == 0 && expected_units.size() == 0)
            $display("** vector3_normalize_core: PASSED **");
        else
            $display("** vector3_normalize_core: FAILED **");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(12 * 400000);
        $display("** vector3_normalize_core: FAILED **");
        $finish;
    end

endmodule
